// File: rtl/pidis_pkg.sv
package pidis_pkg;

	localparam int ERROR_WIDTH_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 12;

	localparam int GAIN_W     = 24;
	localparam int BOUND_W    = 16;
	localparam int SUM_W      = 32;
	localparam int DRIVE_W    = 32;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [SUM_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] S32_MIN = 32'sh8000_0000;

	localparam logic [BOUND_W-1:0]        BOUND_RST       = 16'hFFFF;
	localparam logic signed [DRIVE_W-1:0] DRIVE_UPPER_RST = 32'sd999;
	localparam logic signed [DRIVE_W-1:0] DRIVE_LOWER_RST = -32'sd999;

	typedef enum logic [2:0] {
		CFG_GAIN_PROP,
		CFG_GAIN_INTEG,
		CFG_GAIN_DERIV,
		CFG_SEP_BOUND,
		CFG_INTEG_UPPER,
		CFG_INTEG_LOWER,
		CFG_DRIVE_UPPER,
		CFG_DRIVE_LOWER
	} cfg_index_t;

endpackage

// File: rtl/pidis_if.sv
interface pidis_step_if #(
	parameter int ERROR_WIDTH = pidis_pkg::ERROR_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic signed [ERROR_WIDTH-1:0] error_value;

	modport source (output valid, action, error_value, input ready);
	modport sink   (input valid, action, error_value, output ready);
endinterface

interface pidis_drive_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [pidis_pkg::DRIVE_W-1:0]   drive;
	logic                                   saturated;

	modport source (output valid, drive, saturated, input ready);
	modport sink   (input valid, drive, saturated, output ready);
endinterface

// File: rtl/pid_controller_integral_separation.sv
// channel   dir   payload                        word accepted when
// step      in    action, error_value            step.valid && step.ready
// result    out   drive, saturated               result.valid && result.ready
// cfg       in    cfg_index, cfg_data            cfg_we
//
// one word per cycle while result.ready holds; a control step shows its result after
// acceptance (input stage at the accepting edge, multiply stage, sum stage, output register)
// the integral sum and previous error are updated in the accept cycle, so the next
// word sees them at once; a clear word updates the sum and leaves no result
// each stage holds while the one after it is full and stalled; bubbles are absorbed
// arst_n clears the state, the valid bits and loads the register reset values
module pid_controller_integral_separation #(
	parameter int ERROR_WIDTH    = pidis_pkg::ERROR_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pidis_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pidis_step_if.sink                           step,
	pidis_drive_if.source                        result,
	input  logic                                 cfg_we,
	input  pidis_pkg::cfg_index_t                cfg_index,
	input  logic [pidis_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pidis_pkg::*;

	localparam int MAG_W     = (ERROR_WIDTH > BOUND_W) ? ERROR_WIDTH : BOUND_W;
	localparam int SUM_EXT_W = ((SUM_W > ERROR_WIDTH) ? SUM_W : ERROR_WIDTH) + 1;
	localparam int DELTA_W   = ERROR_WIDTH + 1;
	localparam int PP_W      = GAIN_W + ERROR_WIDTH;
	localparam int PI_W      = GAIN_W + SUM_W;
	localparam int PD_W      = GAIN_W + DELTA_W;
	localparam int ACC_W     = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
	localparam int DRV_W     = ACC_W - GAIN_FRAC_BITS;

	// configuration registers
	logic signed [GAIN_W-1:0]  gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [BOUND_W-1:0]        sep_bound_q;
	logic signed [SUM_W-1:0]   integ_upper_q, integ_lower_q;
	logic signed [DRIVE_W-1:0] drive_upper_q, drive_lower_q;

	// controller state
	logic signed [SUM_W-1:0]       integral_q;
	logic signed [ERROR_WIDTH-1:0] prev_error_q;

	// pipeline
	logic                          v_s1, v_s2, v_s3, out_valid_q;
	logic signed [ERROR_WIDTH-1:0] error_s1;
	logic signed [SUM_W-1:0]       sum_s1;
	logic signed [DELTA_W-1:0]     delta_s1;
	logic signed [PP_W-1:0]        pp_s2;
	logic signed [PI_W-1:0]        pi_s2;
	logic signed [PD_W-1:0]        pd_s2;
	logic signed [ACC_W-1:0]       acc_s3;
	logic signed [DRIVE_W-1:0]     drive_q;
	logic                          sat_q;

	logic adv_out, adv3, adv2, adv1, accept;

	logic signed [ERROR_WIDTH-1:0] err;
	logic [ERROR_WIDTH-1:0]        mag;
	logic                          integrate;
	logic signed [SUM_EXT_W-1:0]   sum_ext;
	logic signed [SUM_W-1:0]       sum_new;
	logic signed [DELTA_W-1:0]     delta;
	logic signed [DRV_W-1:0]       drv_full;
	logic signed [DRIVE_W-1:0]     drv_clamped;
	logic                          drv_sat;

	assign adv_out    = !out_valid_q || result.ready;
	assign adv3       = !v_s3 || adv_out;
	assign adv2       = !v_s2 || adv3;
	assign adv1       = !v_s1 || adv2;
	assign step.ready = adv1;
	assign accept     = step.valid && adv1;

	assign result.valid     = out_valid_q;
	assign result.drive     = drive_q;
	assign result.saturated = sat_q;

	// integral separation and sum clamp, done in the accept cycle
	always_comb begin
		err       = step.error_value;
		mag       = err[ERROR_WIDTH-1] ? ERROR_WIDTH'(-err) : ERROR_WIDTH'(err);
		integrate = MAG_W'(mag) < MAG_W'(sep_bound_q);
		sum_ext   = SUM_EXT_W'(integral_q);
		if (integrate) begin
			sum_ext = sum_ext + SUM_EXT_W'(err);
		end
		// upper limit is checked first, so it wins when the limits are crossed and the sum exceeds it
		if (sum_ext > SUM_EXT_W'(integ_upper_q)) begin
			sum_new = integ_upper_q;
		end else if (sum_ext < SUM_EXT_W'(integ_lower_q)) begin
			sum_new = integ_lower_q;
		end else begin
			sum_new = sum_ext[SUM_W-1:0];
		end
		delta = DELTA_W'(err) - DELTA_W'(prev_error_q);
	end

	// floor by arithmetic shift, then drive clamp
	always_comb begin
		drv_full = DRV_W'(acc_s3 >>> GAIN_FRAC_BITS);
		drv_sat  = 1'b1;
		if (drv_full > DRV_W'(drive_upper_q)) begin
			drv_clamped = drive_upper_q;
		end else if (drv_full < DRV_W'(drive_lower_q)) begin
			drv_clamped = drive_lower_q;
		end else begin
			drv_clamped = drv_full[DRIVE_W-1:0];
			drv_sat     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q   <= '0;
			gain_integ_q  <= '0;
			gain_deriv_q  <= '0;
			sep_bound_q   <= BOUND_RST;
			integ_upper_q <= S32_MAX;
			integ_lower_q <= S32_MIN;
			drive_upper_q <= DRIVE_UPPER_RST;
			drive_lower_q <= DRIVE_LOWER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAIN_PROP:   gain_prop_q   <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_INTEG:  gain_integ_q  <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_DERIV:  gain_deriv_q  <= cfg_data[GAIN_W-1:0];
				CFG_SEP_BOUND:   sep_bound_q   <= cfg_data[BOUND_W-1:0];
				CFG_INTEG_UPPER: integ_upper_q <= cfg_data[SUM_W-1:0];
				CFG_INTEG_LOWER: integ_lower_q <= cfg_data[SUM_W-1:0];
				CFG_DRIVE_UPPER: drive_upper_q <= cfg_data[DRIVE_W-1:0];
				CFG_DRIVE_LOWER: drive_lower_q <= cfg_data[DRIVE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			prev_error_q <= '0;
		end else if (accept) begin
			if (step.action) begin
				integral_q <= '0;
			end else begin
				integral_q   <= sum_new;
				prev_error_q <= err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= step.valid && !step.action;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			error_s1 <= err;
			sum_s1   <= sum_new;
			delta_s1 <= delta;
		end
		if (adv2) begin
			pp_s2 <= PP_W'(gain_prop_q) * PP_W'(error_s1);
			pi_s2 <= PI_W'(gain_integ_q) * PI_W'(sum_s1);
			pd_s2 <= PD_W'(gain_deriv_q) * PD_W'(delta_s1);
		end
		if (adv3) begin
			acc_s3 <= ACC_W'(pp_s2) + ACC_W'(pi_s2) + ACC_W'(pd_s2);
		end
		if (adv_out) begin
			drive_q <= drv_clamped;
			sat_q   <= drv_sat;
		end
	end

	// a clear word leaves a zero sum
	a_clear_zeroes_sum: assert property (@(posedge clk) disable iff (!arst_n)
		accept && step.action |=> integral_q == '0)
		else $error("integral sum not cleared");

	// with ordered limits the stored sum stays inside them
	a_sum_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !step.action && integ_lower_q <= integ_upper_q
		|=> integral_q <= $past(integ_upper_q) && integral_q >= $past(integ_lower_q))
		else $error("integral sum outside its limits");

	// a control step always enters the first stage
	a_step_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !step.action |=> v_s1)
		else $error("control step lost at the input stage");

endmodule
